@@ rtl/arm_command_frame_receiver_macros.svh @@
// Assertion macros for the command frame receiver port checker.
`ifndef ARM_COMMAND_FRAME_RECEIVER_MACROS_SVH
`define ARM_COMMAND_FRAME_RECEIVER_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define ACFR_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset.
`define ACFR_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/acfr_pkg.sv @@
// Shared types and constants for the command frame receiver.
package acfr_pkg;

  // Default number of channels carried by one frame.
  localparam int unsigned CHANNELS_DEFAULT = 6;

  // CRC-16/MODBUS: initial value and reflected polynomial.
  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;

  // Marker reset values ('S' and 'F').
  localparam logic [7:0] START_MARKER_RESET = 8'h53;
  localparam logic [7:0] END_MARKER_RESET   = 8'h46;

  // Configuration port widths.
  localparam int unsigned CFG_INDEX_W = 1;
  localparam int unsigned CFG_DATA_W  = 8;

  // Configuration register indexes.
  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_START_MARKER = 1'b0,
    REG_END_MARKER   = 1'b1
  } cfg_reg_e;

  // Trailer phase after the end marker.
  typedef enum logic [1:0] {
    TRL_BODY = 2'd0,
    TRL_HIGH = 2'd1,
    TRL_LOW  = 2'd2
  } trailer_e;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_RX,
    ST_CRC,
    ST_RD_DIR,
    ST_RD_HI,
    ST_RD_LO,
    ST_LOAD,
    ST_OUT
  } acfr_state_e;

  // Commands from the sequencer to the shared CRC unit.
  typedef struct packed {
    logic       clear;    // return to the initial value
    logic       load;     // fold a byte into the low bits
    logic       restart;  // on load, start from the initial value
    logic       step;     // one bit of the polynomial division
    logic [7:0] data;
  } crc_cmd_t;

endpackage

@@ rtl/acfr_crc_unit.sv @@
// Bit-serial CRC-16/MODBUS unit: one shift step per cycle.
module acfr_crc_unit (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  acfr_pkg::crc_cmd_t cmd_i,
  output logic [15:0]       crc_o
);

  logic [15:0] crc_q;
  logic [15:0] crc_d;

  // Next value: clear, byte load, or one reflected shift step.
  always_comb begin
    crc_d = crc_q;
    if (cmd_i.clear) begin
      crc_d = acfr_pkg::CRC_INIT;
    end else if (cmd_i.load) begin
      crc_d = (cmd_i.restart ? acfr_pkg::CRC_INIT : crc_q) ^ {8'h00, cmd_i.data};
    end else if (cmd_i.step) begin
      crc_d = crc_q[0] ? ((crc_q >> 1) ^ acfr_pkg::CRC_POLY) : (crc_q >> 1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crc_q <= acfr_pkg::CRC_INIT;
    end else begin
      crc_q <= crc_d;
    end
  end

  assign crc_o = crc_q;

endmodule

@@ rtl/acfr_frame_store.sv @@
// Frame byte memory: one write port, one registered read port.
module acfr_frame_store #(
  parameter int unsigned DEPTH = 18,
  parameter int unsigned AW    = 5
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [7:0]    wdata_i,
  input  logic [AW-1:0] raddr_i,
  output logic [7:0]    rdata_o
);

  logic [7:0] mem_q [DEPTH];
  logic [7:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/arm_command_frame_receiver.sv @@
// Command frame receiver: byte deframer with CRC-16/MODBUS check.
//
//  Channel  | Direction | Signals
//  ---------+-----------+--------------------------------------------------
//  rx       | in        | in_valid_i, in_ready_o, rx_byte_i
//  result   | out       | out_valid_o, out_ready_i, channel_o, direction_o,
//           |           | magnitude_o, last_o
//  config   | in        | cfg_we_i, cfg_index_i, cfg_data_i
//
// A start or data byte is accepted and then takes 8 steps of the shared
// bit-serial CRC unit; other bytes need only the accept.
// A good frame then yields CHANNELS results, each read through the single read
// port of the frame memory in RD_DIR, RD_HI, RD_LO and LOAD, plus any stall on the output.
// Input ready is low while the CRC unit runs and while results are sent.
// Reset is asynchronous; the frame memory is not cleared and needs no pass.
module arm_command_frame_receiver #(
  parameter int unsigned CHANNELS = acfr_pkg::CHANNELS_DEFAULT
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic [7:0]                       rx_byte_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic [3:0]                       channel_o,
  output logic [7:0]                       direction_o,
  output logic [15:0]                      magnitude_o,
  output logic                             last_o,
  input  logic                             cfg_we_i,
  input  logic [acfr_pkg::CFG_INDEX_W-1:0] cfg_index_i,
  input  logic [acfr_pkg::CFG_DATA_W-1:0]  cfg_data_i
);

  localparam int unsigned BODY_LEN    = 3 * CHANNELS + 1;
  localparam int unsigned STORE_DEPTH = 3 * CHANNELS;
  localparam int unsigned AW          = $clog2(STORE_DEPTH);
  localparam int unsigned NW          = $clog2(BODY_LEN + 1);
  localparam int unsigned CW          = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  acfr_pkg::acfr_state_e state_q, state_d;
  acfr_pkg::trailer_e    trailer_q, trailer_d;
  acfr_pkg::crc_cmd_t    crc_cmd;

  logic [7:0]    start_marker_q;
  logic [7:0]    end_marker_q;
  logic          receiving_q, receiving_d;
  logic [NW-1:0] byte_count_q, byte_count_d;
  logic [2:0]    bit_cnt_q;
  logic [CW-1:0] ch_q;
  logic [7:0]    crc_rx_hi_q;
  logic [7:0]    dir_q;
  logic [15:0]   mag_q;
  logic [15:0]   crc;
  logic [7:0]    rdata;
  logic [AW-1:0] raddr;
  logic [AW-1:0] mag_addr;
  logic          store_we;
  logic [AW-1:0] store_waddr;

  logic in_acc;
  logic out_acc;
  logic is_trl_hi, is_trl_lo, is_start, is_end, is_ovf, is_data;
  logic frame_ok;
  logic ch_last;

  // Configuration writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_marker_q <= acfr_pkg::START_MARKER_RESET;
      end_marker_q   <= acfr_pkg::END_MARKER_RESET;
    end else if (cfg_we_i) begin
      case (acfr_pkg::cfg_reg_e'(cfg_index_i))
        acfr_pkg::REG_START_MARKER: start_marker_q <= cfg_data_i;
        acfr_pkg::REG_END_MARKER:   end_marker_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Decode of the accepted byte; trailer bytes take precedence over markers.
  assign in_acc    = in_valid_i && in_ready_o;
  assign out_acc   = out_valid_o && out_ready_i;
  assign is_trl_hi = in_acc && receiving_q && (trailer_q == acfr_pkg::TRL_HIGH);
  assign is_trl_lo = in_acc && receiving_q && (trailer_q == acfr_pkg::TRL_LOW);
  assign is_start  = in_acc && !is_trl_hi && !is_trl_lo && (rx_byte_i == start_marker_q);
  assign is_end    = in_acc && !is_trl_hi && !is_trl_lo && !is_start && receiving_q
                     && (rx_byte_i == end_marker_q);
  assign is_ovf    = in_acc && !is_trl_hi && !is_trl_lo && !is_start && receiving_q
                     && !is_end && (byte_count_q >= NW'(BODY_LEN));
  assign is_data   = in_acc && !is_trl_hi && !is_trl_lo && !is_start && receiving_q
                     && !is_end && !is_ovf;
  assign frame_ok  = (byte_count_q == NW'(BODY_LEN)) && ({crc_rx_hi_q, rx_byte_i} == crc);
  assign ch_last   = (ch_q == CW'(CHANNELS - 1));

  // Frame tracking: receiving flag, body length and trailer phase.
  always_comb begin
    receiving_d  = receiving_q;
    byte_count_d = byte_count_q;
    trailer_d    = trailer_q;
    if (is_trl_hi) begin
      trailer_d = acfr_pkg::TRL_LOW;
    end else if (is_trl_lo || is_ovf) begin
      receiving_d  = 1'b0;
      byte_count_d = '0;
      trailer_d    = acfr_pkg::TRL_BODY;
    end else if (is_start) begin
      receiving_d  = 1'b1;
      byte_count_d = NW'(1);
      trailer_d    = acfr_pkg::TRL_BODY;
    end else if (is_end) begin
      trailer_d = acfr_pkg::TRL_HIGH;
    end else if (is_data) begin
      byte_count_d = byte_count_q + NW'(1);
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      acfr_pkg::ST_RX: begin
        if (is_start || is_data) begin
          state_d = acfr_pkg::ST_CRC;
        end else if (is_trl_lo && frame_ok) begin
          state_d = acfr_pkg::ST_RD_DIR;
        end
      end
      acfr_pkg::ST_CRC: begin
        if (bit_cnt_q == 3'd7) begin
          state_d = acfr_pkg::ST_RX;
        end
      end
      acfr_pkg::ST_RD_DIR: state_d = acfr_pkg::ST_RD_HI;
      acfr_pkg::ST_RD_HI:  state_d = acfr_pkg::ST_RD_LO;
      acfr_pkg::ST_RD_LO:  state_d = acfr_pkg::ST_LOAD;
      acfr_pkg::ST_LOAD:   state_d = acfr_pkg::ST_OUT;
      acfr_pkg::ST_OUT: begin
        if (out_acc) begin
          state_d = ch_last ? acfr_pkg::ST_RX : acfr_pkg::ST_RD_DIR;
        end
      end
      default: state_d = acfr_pkg::ST_RX;
    endcase
  end

  // Magnitude bytes of channel i sit after the direction bytes, two each.
  assign mag_addr = AW'(CHANNELS) + AW'({ch_q, 1'b0});

  // Sequencer outputs: handshakes, CRC commands and memory addresses.
  always_comb begin
    in_ready_o      = 1'b0;
    out_valid_o     = 1'b0;
    raddr           = '0;
    crc_cmd.clear   = 1'b0;
    crc_cmd.load    = 1'b0;
    crc_cmd.restart = 1'b0;
    crc_cmd.step    = 1'b0;
    crc_cmd.data    = rx_byte_i;
    case (state_q)
      acfr_pkg::ST_RX: begin
        in_ready_o      = 1'b1;
        crc_cmd.clear   = is_trl_lo || is_ovf;
        crc_cmd.load    = is_start || is_data;
        crc_cmd.restart = is_start;
      end
      acfr_pkg::ST_CRC:    crc_cmd.step = 1'b1;
      acfr_pkg::ST_RD_DIR: raddr = AW'(ch_q);
      acfr_pkg::ST_RD_HI:  raddr = mag_addr;
      acfr_pkg::ST_RD_LO:  raddr = mag_addr + AW'(1);
      acfr_pkg::ST_LOAD:   raddr = '0;
      acfr_pkg::ST_OUT:    out_valid_o = 1'b1;
      default: ;
    endcase
  end

  // Data bytes go to the memory; the start byte and end marker are not kept.
  assign store_we    = is_data;
  assign store_waddr = AW'(byte_count_q - NW'(1));

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= acfr_pkg::ST_RX;
      trailer_q    <= acfr_pkg::TRL_BODY;
      receiving_q  <= 1'b0;
      byte_count_q <= '0;
      bit_cnt_q    <= '0;
      ch_q         <= '0;
    end else begin
      state_q      <= state_d;
      trailer_q    <= trailer_d;
      receiving_q  <= receiving_d;
      byte_count_q <= byte_count_d;
      bit_cnt_q    <= (state_q == acfr_pkg::ST_CRC) ? bit_cnt_q + 3'd1 : 3'd0;
      if (is_trl_lo) begin
        ch_q <= '0;
      end else if (out_acc && !ch_last) begin
        ch_q <= ch_q + CW'(1);
      end
    end
  end

  // Payload registers: received CRC high byte and the result fields.
  always_ff @(posedge clk_i) begin
    if (is_trl_hi) begin
      crc_rx_hi_q <= rx_byte_i;
    end
    if (state_q == acfr_pkg::ST_RD_HI) begin
      dir_q <= rdata;
    end
    if (state_q == acfr_pkg::ST_RD_LO) begin
      mag_q[15:8] <= rdata;
    end
    if (state_q == acfr_pkg::ST_LOAD) begin
      mag_q[7:0] <= rdata;
    end
  end

  assign channel_o   = 4'(ch_q);
  assign direction_o = dir_q;
  assign magnitude_o = mag_q;
  assign last_o      = ch_last;

  acfr_crc_unit u_crc (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (crc_cmd),
    .crc_o  (crc)
  );

  acfr_frame_store #(
    .DEPTH (STORE_DEPTH),
    .AW    (AW)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (store_we),
    .waddr_i (store_waddr),
    .wdata_i (rx_byte_i),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

endmodule

@@ rtl/acfr_port_checker.sv @@
// Port-level checker for the command frame receiver, with its bind.
`include "arm_command_frame_receiver_macros.svh"

module acfr_port_checker #(
  parameter int unsigned CHANNELS = acfr_pkg::CHANNELS_DEFAULT
) (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_ready_o,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic [3:0] channel_o,
  input logic [7:0] direction_o,
  input logic       last_o
);

  // A result waiting for the sink keeps its direction byte.
  `ACFR_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i, out_valid_o && $stable(direction_o), "result changed while stalled")

  // Results and new input bytes never overlap.
  `ACFR_ASSERT_NOW(a_no_overlap, clk_i, rst_ni, out_valid_o, !in_ready_o, "input ready while a result is pending")

  // The last flag marks exactly the final channel.
  `ACFR_ASSERT_NOW(a_last_channel, clk_i, rst_ni, out_valid_o, last_o == (channel_o == 4'(CHANNELS - 1)), "last flag does not match the channel")

  // A run of results is not interrupted by input before its last entry.
  `ACFR_ASSERT_NEXT(a_run_busy, clk_i, rst_ni, out_valid_o && out_ready_i && !last_o, !in_ready_o, "input taken in the middle of a result run")

endmodule

bind arm_command_frame_receiver acfr_port_checker #(.CHANNELS(CHANNELS)) u_port_checker (.*);
